[sv/sqvt_pkg.sv]
// Shared constants, types and the quarter-wave sine table of the sprite quad vertex transform.
`default_nettype none

package sqvt_pkg;

    // Sine table size: 2^SINE_TABLE_BITS entries per full turn
    localparam int SINE_TABLE_BITS = 10;
    localparam int QUARTER_LEN     = 1 << (SINE_TABLE_BITS - 2);
    localparam int QIDX_W          = SINE_TABLE_BITS - 1;
    localparam int ANGLE_W         = 16;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    // Field widths
    localparam int COORD_W    = 32;
    localparam int SCALE_W    = 16;
    localparam int RECT_W     = 31;
    localparam int CORNER_W   = 2;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W = 32;

    // Fixed-point fractions
    localparam int SCALE_FRAC = 8;
    localparam int TRIG_W     = 16;
    localparam int TRIG_FRAC  = 15;

    // Datapath widths, each derived from the previous step
    localparam int DIFF_W    = COORD_W + 2;
    localparam int SPROD_W   = DIFF_W + SCALE_W;
    localparam int OFS_W     = SPROD_W - SCALE_FRAC;
    localparam int RPROD_W   = OFS_W + TRIG_W;
    localparam int ROT_SUM_W = RPROD_W + 1;
    localparam int ROT_W     = ROT_SUM_W - TRIG_FRAC;
    localparam int TPROD_W   = ROT_W + TRIG_W;
    localparam int TILT_W    = TPROD_W - TRIG_FRAC;
    localparam int SUM_W     = TILT_W + 1;

    // Half-LSB rounding constants
    localparam logic signed [SPROD_W-1:0]   SCALE_RND = SPROD_W'(1) << (SCALE_FRAC - 1);
    localparam logic signed [ROT_SUM_W-1:0] ROT_RND   = ROT_SUM_W'(1) << (TRIG_FRAC - 1);
    localparam logic signed [TPROD_W-1:0]   TILT_RND  = TPROD_W'(1) << (TRIG_FRAC - 1);

    // Saturation limits
    localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // Corner codes
    localparam logic [CORNER_W-1:0] CORNER_TL = 2'd0;
    localparam logic [CORNER_W-1:0] CORNER_TR = 2'd1;
    localparam logic [CORNER_W-1:0] CORNER_BR = 2'd2;
    localparam logic [CORNER_W-1:0] CORNER_BL = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X    = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y    = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_H     = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_V     = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RECT_WIDTH  = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_RECT_HEIGHT = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TURN_ANGLE  = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_TILT_ANGLE  = 4'd7;

    // Configuration reset values
    localparam logic [SCALE_W-1:0] SCALE_ONE = 16'd256;
    localparam logic [RECT_W-1:0]  RECT_ONE  = 31'd65536;

    typedef logic [TRIG_W-1:0] qsine_tbl_t [0:QUARTER_LEN];

    // Build the quarter-wave table from an eight-term Taylor series in Q30
    function automatic qsine_tbl_t build_qsine();
        qsine_tbl_t tbl;
        longint x;
        longint x2;
        longint term;
        longint sum;
        for (int k = 0; k <= QUARTER_LEN; k++) begin
            x    = (HALF_PI_Q30 * longint'(k)) >>> (SINE_TABLE_BITS - 2);
            x2   = (x * x) >>> 30;
            term = x;
            sum  = x;
            for (int n = 1; n <= 7; n++) begin
                term = (term * x2) >>> 30;
                case (n)
                    1: begin
                        term = term / 6;
                    end
                    2: begin
                        term = term / 20;
                    end
                    3: begin
                        term = term / 42;
                    end
                    4: begin
                        term = term / 72;
                    end
                    5: begin
                        term = term / 110;
                    end
                    6: begin
                        term = term / 156;
                    end
                    default: begin
                        term = term / 210;
                    end
                endcase
                if (n % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            sum = (sum + 64'sd16384) >>> 15;
            if (sum > 32767) begin
                sum = 32767;
            end
            tbl[k] = TRIG_W'(sum);
        end
        return tbl;
    endfunction

    localparam qsine_tbl_t QSINE_TBL = build_qsine();

    // Table index of an angle
    function automatic logic [SINE_TABLE_BITS-1:0] angle_index(input logic [ANGLE_W-1:0] a);
        return a[ANGLE_W-1 -: SINE_TABLE_BITS];
    endfunction

    // Signed Q1.15 sine at a full-turn table index
    function automatic logic signed [TRIG_W-1:0] trig_value(
        input logic [SINE_TABLE_BITS-1:0] idx
    );
        logic [QIDX_W-1:0] r;
        logic [QIDX_W-1:0] m;
        logic [TRIG_W-1:0] e;
        r = QIDX_W'(idx[SINE_TABLE_BITS-3:0]);
        m = QIDX_W'(QUARTER_LEN) - r;
        // second and fourth quadrants mirror, third and fourth negate
        e = idx[SINE_TABLE_BITS-2] ? QSINE_TBL[m] : QSINE_TBL[r];
        return idx[SINE_TABLE_BITS-1] ? $signed(-e) : $signed(e);
    endfunction

endpackage

`default_nettype wire

[sv/sprite_quad_vertex_transform.sv]
// An accepted sprite waits in the corner issue register while its corners enter the
// 8-stage pipe for m_tvalid, one corner per cycle unless m_tready stalls the pipe;
// the next sprite is accepted as the current one issues its last corner.
// Stages advance independently, so bubbles close up while the output waits.
// Reset (aresetn low, synchronous) empties the pipe and loads configuration defaults.
`default_nettype none

module sprite_quad_vertex_transform
    import sqvt_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // configuration write channel
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    // sprite input
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [2*COORD_W-1:0]   s_tdata,   // pos_x [31:0], pos_y [63:32]
    // vertex output
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [2*COORD_W-1:0]        m_tdata,   // vert_x [31:0], vert_y [63:32]
    output logic [CORNER_W-1:0]         m_tuser,   // corner [1:0]
    output logic                        m_tlast
);

    localparam int NSTG = 8;

    typedef struct packed {
        logic [CORNER_W-1:0] corner;
        logic [COORD_W-1:0]  pos_x;
        logic [COORD_W-1:0]  pos_y;
    } vtx_tag_t;

    // Configuration registers
    logic signed [COORD_W-1:0] center_x_reg;
    logic signed [COORD_W-1:0] center_y_reg;
    logic signed [SCALE_W-1:0] scale_h_reg;
    logic signed [SCALE_W-1:0] scale_v_reg;
    logic [RECT_W-1:0]         rect_width_reg;
    logic [RECT_W-1:0]         rect_height_reg;
    logic [ANGLE_W-1:0]        turn_angle_reg;
    logic [ANGLE_W-1:0]        tilt_angle_reg;

    // Trig values follow the angle registers
    logic signed [TRIG_W-1:0] sin_reg, cos_reg, tcos_reg;
    logic                     turn_on_reg, tilt_on_reg;

    // Corner issue
    logic                 busy_reg, busy_next;
    logic [CORNER_W-1:0]  cnt_reg, cnt_next;
    logic [COORD_W-1:0]   pos_x_reg, pos_y_reg;
    logic                 issue, s_acc;

    // Pipeline control
    logic [NSTG:1]        vld_reg, vld_next;
    logic [NSTG:1]        adv;
    vtx_tag_t             tag_reg [1:NSTG];

    // Datapath
    logic signed [DIFF_W-1:0]    s1_dx_reg, s1_dx_next, s1_dy_reg, s1_dy_next;
    logic signed [SPROD_W-1:0]   s2_xp_reg, s2_xp_next, s2_yp_reg, s2_yp_next;
    logic signed [OFS_W-1:0]     s3_ox_reg, s3_ox_next, s3_oy_reg, s3_oy_next;
    logic signed [RPROD_W-1:0]   s4_pxc_reg, s4_pxc_next, s4_pys_reg, s4_pys_next;
    logic signed [RPROD_W-1:0]   s4_pxs_reg, s4_pxs_next, s4_pyc_reg, s4_pyc_next;
    logic signed [OFS_W-1:0]     s4_ox_reg, s4_oy_reg;
    logic signed [ROT_W-1:0]     s5_rx_reg, s5_rx_next, s5_ry_reg, s5_ry_next;
    logic signed [TPROD_W-1:0]   s6_tp_reg, s6_tp_next;
    logic signed [ROT_W-1:0]     s6_rx_reg, s6_ry_reg;
    logic signed [ROT_W-1:0]     s7_rx_reg;
    logic signed [TILT_W-1:0]    s7_ry_reg, s7_ry_next;
    logic [COORD_W-1:0]          s8_vx_reg, s8_vx_next, s8_vy_reg, s8_vy_next;

    logic signed [DIFF_W-1:0]    cx_ext, cy_ext, rw_ext, rh_ext;
    logic signed [SPROD_W-1:0]   xr_sum, yr_sum;
    logic signed [ROT_SUM_W-1:0] rsx_sum, rsy_sum;
    logic signed [TPROD_W-1:0]   ts_sum;
    logic signed [SUM_W-1:0]     fx_sum, fy_sum;
    logic                        right_c, bottom_c;

    // Clamp a wide sum to the signed coordinate range
    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
        if ((&v[SUM_W-1:COORD_W-1]) || !(|v[SUM_W-1:COORD_W-1])) begin
            return v[COORD_W-1:0];
        end else if (v[SUM_W-1]) begin
            return COORD_MIN;
        end else begin
            return COORD_MAX;
        end
    endfunction

    // Write configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            scale_h_reg     <= SCALE_ONE;
            scale_v_reg     <= SCALE_ONE;
            rect_width_reg  <= RECT_ONE;
            rect_height_reg <= RECT_ONE;
            turn_angle_reg  <= '0;
            tilt_angle_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_CENTER_X:    center_x_reg    <= cfg_data;
                REG_CENTER_Y:    center_y_reg    <= cfg_data;
                REG_SCALE_H:     scale_h_reg     <= cfg_data[SCALE_W-1:0];
                REG_SCALE_V:     scale_v_reg     <= cfg_data[SCALE_W-1:0];
                REG_RECT_WIDTH:  rect_width_reg  <= cfg_data[RECT_W-1:0];
                REG_RECT_HEIGHT: rect_height_reg <= cfg_data[RECT_W-1:0];
                REG_TURN_ANGLE:  turn_angle_reg  <= cfg_data[ANGLE_W-1:0];
                REG_TILT_ANGLE:  tilt_angle_reg  <= cfg_data[ANGLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Look up sine and cosine of the turn angle and cosine of the tilt angle every cycle
    always_ff @(posedge aclk) begin
        sin_reg     <= trig_value(angle_index(turn_angle_reg));
        cos_reg     <= trig_value(angle_index(turn_angle_reg) +
                                  SINE_TABLE_BITS'(QUARTER_LEN));
        tcos_reg    <= trig_value(angle_index(tilt_angle_reg) +
                                  SINE_TABLE_BITS'(QUARTER_LEN));
        turn_on_reg <= (turn_angle_reg != '0);
        tilt_on_reg <= (tilt_angle_reg != '0);
    end

    // Stage ready chain: a stage loads when it is empty or its successor loads
    always_comb begin
        adv[NSTG] = !vld_reg[NSTG] || m_tready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    // Issue four corners per sprite
    assign issue    = busy_reg && adv[1];
    assign s_tready = !busy_reg || (issue && (cnt_reg == CORNER_BL));
    assign s_acc    = s_tvalid && s_tready;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (s_acc) begin
            busy_next = 1'b1;
            cnt_next  = CORNER_TL;
        end else if (issue) begin
            cnt_next = CORNER_W'(cnt_reg + 1'b1);
            if (cnt_reg == CORNER_BL) begin
                busy_next = 1'b0;
            end
        end
    end

    // Advance valid bits
    always_comb begin
        vld_next[1] = adv[1] ? busy_reg : vld_reg[1];
        for (int k = 2; k <= NSTG; k++) begin
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= CORNER_TL;
            vld_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            vld_reg  <= vld_next;
        end
    end

    // Datapath next values
    always_comb begin
        // stage 1: corner offset from the pivot, unscaled
        right_c    = cnt_reg[0] ^ cnt_reg[1];
        bottom_c   = cnt_reg[1];
        cx_ext     = DIFF_W'(center_x_reg);
        cy_ext     = DIFF_W'(center_y_reg);
        rw_ext     = $signed(DIFF_W'(rect_width_reg));
        rh_ext     = $signed(DIFF_W'(rect_height_reg));
        s1_dx_next = right_c  ? (rw_ext - cx_ext) : -cx_ext;
        s1_dy_next = bottom_c ? (rh_ext - cy_ext) : -cy_ext;

        // stage 2: apply scale
        s2_xp_next = s1_dx_reg * scale_h_reg;
        s2_yp_next = s1_dy_reg * scale_v_reg;

        // stage 3: round scaled offset back to Q26.16
        xr_sum     = s2_xp_reg + SCALE_RND;
        yr_sum     = s2_yp_reg + SCALE_RND;
        s3_ox_next = xr_sum[SPROD_W-1:SCALE_FRAC];
        s3_oy_next = yr_sum[SPROD_W-1:SCALE_FRAC];

        // stage 4: rotation products
        s4_pxc_next = s3_ox_reg * cos_reg;
        s4_pys_next = s3_oy_reg * sin_reg;
        s4_pxs_next = s3_ox_reg * sin_reg;
        s4_pyc_next = s3_oy_reg * cos_reg;

        // stage 5: combine and round, or pass the offset when unrotated
        rsx_sum = ROT_SUM_W'(s4_pxc_reg) - ROT_SUM_W'(s4_pys_reg) + ROT_RND;
        rsy_sum = ROT_SUM_W'(s4_pxs_reg) + ROT_SUM_W'(s4_pyc_reg) + ROT_RND;
        s5_rx_next = turn_on_reg ? rsx_sum[ROT_SUM_W-1:TRIG_FRAC] : ROT_W'(s4_ox_reg);
        s5_ry_next = turn_on_reg ? rsy_sum[ROT_SUM_W-1:TRIG_FRAC] : ROT_W'(s4_oy_reg);

        // stage 6: tilt product
        s6_tp_next = s5_ry_reg * tcos_reg;

        // stage 7: round tilt, or pass y when untilted
        ts_sum     = s6_tp_reg + TILT_RND;
        s7_ry_next = tilt_on_reg ? ts_sum[TPROD_W-1:TRIG_FRAC] : TILT_W'(s6_ry_reg);

        // stage 8: add the position and saturate
        fx_sum     = SUM_W'(s7_rx_reg) + SUM_W'($signed(tag_reg[NSTG-1].pos_x));
        fy_sum     = SUM_W'(s7_ry_reg) + SUM_W'($signed(tag_reg[NSTG-1].pos_y));
        s8_vx_next = sat_coord(fx_sum);
        s8_vy_next = sat_coord(fy_sum);
    end

    // Payload registers, each stage loads with its ready
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            pos_x_reg <= s_tdata[COORD_W-1:0];
            pos_y_reg <= s_tdata[2*COORD_W-1:COORD_W];
        end
        if (adv[1]) begin
            tag_reg[1] <= '{corner: cnt_reg, pos_x: pos_x_reg, pos_y: pos_y_reg};
            s1_dx_reg  <= s1_dx_next;
            s1_dy_reg  <= s1_dy_next;
        end
        for (int k = 2; k <= NSTG; k++) begin
            if (adv[k]) begin
                tag_reg[k] <= tag_reg[k-1];
            end
        end
        if (adv[2]) begin
            s2_xp_reg <= s2_xp_next;
            s2_yp_reg <= s2_yp_next;
        end
        if (adv[3]) begin
            s3_ox_reg <= s3_ox_next;
            s3_oy_reg <= s3_oy_next;
        end
        if (adv[4]) begin
            s4_pxc_reg <= s4_pxc_next;
            s4_pys_reg <= s4_pys_next;
            s4_pxs_reg <= s4_pxs_next;
            s4_pyc_reg <= s4_pyc_next;
            s4_ox_reg  <= s3_ox_reg;
            s4_oy_reg  <= s3_oy_reg;
        end
        if (adv[5]) begin
            s5_rx_reg <= s5_rx_next;
            s5_ry_reg <= s5_ry_next;
        end
        if (adv[6]) begin
            s6_tp_reg <= s6_tp_next;
            s6_rx_reg <= s5_rx_reg;
            s6_ry_reg <= s5_ry_reg;
        end
        if (adv[7]) begin
            s7_rx_reg <= s6_rx_reg;
            s7_ry_reg <= s7_ry_next;
        end
        if (adv[8]) begin
            s8_vx_reg <= s8_vx_next;
            s8_vy_reg <= s8_vy_next;
        end
    end

    // Drive the vertex output
    assign m_tvalid = vld_reg[NSTG];
    assign m_tdata  = {s8_vy_reg, s8_vx_reg};
    assign m_tuser  = tag_reg[NSTG].corner;
    assign m_tlast  = (tag_reg[NSTG].corner == CORNER_BL);

endmodule

`default_nettype wire

[sv/sqvt_checker.sv]
// Port-level checker for the sprite quad vertex transform, bound to the top level.
`default_nettype none

module sqvt_checker
    import sqvt_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [2*COORD_W-1:0]   m_tdata,
    input wire logic [CORNER_W-1:0]    m_tuser,
    input wire logic                   m_tlast
);

    logic [CORNER_W-1:0] exp_corner_reg;
    logic [4:0]          pend_reg;
    logic                in_acc, out_acc;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // Track the next corner expected and the corners still owed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_corner_reg <= CORNER_TL;
            pend_reg       <= '0;
        end else begin
            if (out_acc) begin
                exp_corner_reg <= CORNER_W'(exp_corner_reg + 1'b1);
            end
            pend_reg <= pend_reg + (in_acc ? 5'd4 : 5'd0) - (out_acc ? 5'd1 : 5'd0);
        end
    end

    a_corner_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == exp_corner_reg))
        else $error("corner out of order");

    a_last_on_bl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == CORNER_BL)))
        else $error("tlast not on bottom-left corner");

    a_no_extra: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (pend_reg != 5'd0))
        else $error("vertex without a pending sprite");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled vertex changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind sprite_quad_vertex_transform sqvt_checker u_sqvt_checker (.*);

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the sprite quad vertex transform: predicts and checks four corners per sprite.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sqvt_pkg::*;

    localparam int CLK_PERIOD      = 4;
    localparam int RESET_CYCLES    = 6;
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 39;
    localparam int IDLE_PCT        = 38;
    localparam int MAX_GAP         = 6;
    localparam int CALM_PHASE      = 2;
    localparam int HOLD_PHASE      = 5;
    localparam int HOLD_CYCLES     = 300;
    localparam int STALL_LIMIT     = 4000;
    localparam int SETTLE_CYCLES   = 16;
    localparam int REPORT_LIMIT    = 10;
    localparam int NUM_REGS        = 8;
    localparam int Q30_FRAC        = 30;
    localparam int SERIES_TERMS    = 7;
    localparam int TURN_LEN        = 1 << SINE_TABLE_BITS;
    localparam longint COORD_HI    = (longint'(1) << (COORD_W - 1)) - 1;
    localparam longint COORD_LO    = -(longint'(1) << (COORD_W - 1));
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = REG_TILT_ANGLE + 1'b1;
    localparam logic [CORNER_W-1:0] CORNER_ORDER [0:3] =
        '{CORNER_TL, CORNER_TR, CORNER_BR, CORNER_BL};

    typedef struct {
        logic [CORNER_W-1:0] corner;
        logic [COORD_W-1:0]  vx;
        logic [COORD_W-1:0]  vy;
        logic                last;
    } vertex_t;

    // One value per register, in register index order
    typedef logic [CFG_DATA_W-1:0] cfg_set_t [0:NUM_REGS-1];

    // Vertex predictor and store of corners still to come
    class quad_checker;
        longint qsin [0:QUARTER_LEN];
        logic signed [COORD_W-1:0] ctr_x, ctr_y;
        logic signed [SCALE_W-1:0] scl_h, scl_v;
        logic [RECT_W-1:0]         rect_w, rect_h;
        logic [ANGLE_W-1:0]        turn, tilt;
        vertex_t                   due_corners [$];
        int sprites;
        int corners_ok;
        int mismatches;

        // Build the quarter-wave sine from the Taylor series and load reset values
        function new();
            longint x, x2, term, acc;
            int k, n;
            for (k = 0; k <= QUARTER_LEN; k++) begin
                x    = (HALF_PI_Q30 * longint'(k)) / QUARTER_LEN;
                x2   = (x * x) >>> Q30_FRAC;
                term = x;
                acc  = x;
                for (n = 1; n <= SERIES_TERMS; n++) begin
                    term = (term * x2) >>> Q30_FRAC;
                    term = term / ((2 * n) * (2 * n + 1));
                    if (n % 2 == 1) begin
                        acc -= term;
                    end else begin
                        acc += term;
                    end
                end
                if (acc < 0) begin
                    acc = 0;
                end
                acc = (acc + (longint'(1) << (TRIG_FRAC - 1))) >>> TRIG_FRAC;
                if (acc > (longint'(1) << TRIG_FRAC) - 1) begin
                    acc = (longint'(1) << TRIG_FRAC) - 1;
                end
                qsin[k] = acc;
            end
            ctr_x      = '0;
            ctr_y      = '0;
            scl_h      = SCALE_ONE;
            scl_v      = SCALE_ONE;
            rect_w     = RECT_ONE;
            rect_h     = RECT_ONE;
            turn       = '0;
            tilt       = '0;
            sprites    = 0;
            corners_ok = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_CENTER_X: begin
                    ctr_x = data[COORD_W-1:0];
                end
                REG_CENTER_Y: begin
                    ctr_y = data[COORD_W-1:0];
                end
                REG_SCALE_H: begin
                    scl_h = data[SCALE_W-1:0];
                end
                REG_SCALE_V: begin
                    scl_v = data[SCALE_W-1:0];
                end
                REG_RECT_WIDTH: begin
                    rect_w = data[RECT_W-1:0];
                end
                REG_RECT_HEIGHT: begin
                    rect_h = data[RECT_W-1:0];
                end
                REG_TURN_ANGLE: begin
                    turn = data[ANGLE_W-1:0];
                end
                REG_TILT_ANGLE: begin
                    tilt = data[ANGLE_W-1:0];
                end
                default: begin
                    // unmapped index: the block drops the write
                end
            endcase
        endfunction

        function int pending();
            return due_corners.size();
        endfunction

        function int unsigned table_index(logic [ANGLE_W-1:0] a);
            return a >> (ANGLE_W - SINE_TABLE_BITS);
        endfunction

        // Signed Q1.15 sine at a full-turn index, mirrored from the quarter wave
        function longint sine_at(int unsigned i);
            int unsigned j, r;
            j = i % TURN_LEN;
            r = j % QUARTER_LEN;
            case (j / QUARTER_LEN)
                0: begin
                    return qsin[r];
                end
                1: begin
                    return qsin[QUARTER_LEN - r];
                end
                2: begin
                    return -qsin[r];
                end
                default: begin
                    return -qsin[QUARTER_LEN - r];
                end
            endcase
        endfunction

        // Divide by 2^k, halves rounding toward plus infinity
        function longint half_up_shift(longint v, int k);
            return (v + (longint'(1) << (k - 1))) >>> k;
        endfunction

        function logic [COORD_W-1:0] saturate(longint v);
            if (v > COORD_HI) begin
                return COORD_MAX;
            end
            if (v < COORD_LO) begin
                return COORD_MIN;
            end
            return v[COORD_W-1:0];
        endfunction

        // Work out the four corners of an accepted sprite and queue them
        function void note_sprite(logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
            longint left, right, top, bottom;
            longint sn, cs, ct, ox, oy, rx, ry;
            logic [CORNER_W-1:0] code;
            vertex_t v;
            int c;
            left   = half_up_shift(-longint'(ctr_x) * longint'(scl_h), SCALE_FRAC);
            right  = half_up_shift((longint'(rect_w) - longint'(ctr_x)) * longint'(scl_h),
                                   SCALE_FRAC);
            top    = half_up_shift(-longint'(ctr_y) * longint'(scl_v), SCALE_FRAC);
            bottom = half_up_shift((longint'(rect_h) - longint'(ctr_y)) * longint'(scl_v),
                                   SCALE_FRAC);
            sn = 0;
            cs = 0;
            ct = 0;
            if (turn != 0) begin
                sn = sine_at(table_index(turn));
                cs = sine_at(table_index(turn) + QUARTER_LEN);
            end
            if (tilt != 0) begin
                ct = sine_at(table_index(tilt) + QUARTER_LEN);
            end
            for (c = 0; c < 4; c++) begin
                code = CORNER_ORDER[c];
                ox = (code == CORNER_TR || code == CORNER_BR) ? right : left;
                oy = (code == CORNER_BR || code == CORNER_BL) ? bottom : top;
                // a zero angle bypasses the table multiply altogether
                if (turn != 0) begin
                    rx = half_up_shift(ox * cs - oy * sn, TRIG_FRAC);
                    ry = half_up_shift(ox * sn + oy * cs, TRIG_FRAC);
                end else begin
                    rx = ox;
                    ry = oy;
                end
                if (tilt != 0) begin
                    ry = half_up_shift(ry * ct, TRIG_FRAC);
                end
                v.corner = code;
                v.vx     = saturate(rx + longint'($signed(px)));
                v.vy     = saturate(ry + longint'($signed(py)));
                v.last   = (code == CORNER_BL);
                due_corners.insert(due_corners.size(), v);
            end
            sprites++;
        endfunction

        function void flag_error(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("[%0t] ERROR: %s", $realtime, msg);
            end
        endfunction

        // Compare an accepted vertex with the oldest queued corner
        function void check_vertex(logic [CORNER_W-1:0] corner, logic [COORD_W-1:0] vx,
                                   logic [COORD_W-1:0] vy, logic last);
            vertex_t want;
            if (due_corners.size() == 0) begin
                flag_error($sformatf("vertex with none expected: corner %0d x %h y %h last %b",
                                     corner, vx, vy, last));
            end else begin
                want = due_corners.pop_front();
                if (want.corner !== corner || want.vx !== vx || want.vy !== vy
                        || want.last !== last) begin
                    flag_error($sformatf(
                        "want corner %0d x %h y %h last %b, got corner %0d x %h y %h last %b",
                        want.corner, want.vx, want.vy, want.last, corner, vx, vy, last));
                end else begin
                    corners_ok++;
                end
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [2*COORD_W-1:0]   s_tdata;    // pos_x [31:0], pos_y [63:32]
    logic                   m_tvalid;
    logic                   m_tready;
    logic [2*COORD_W-1:0]   m_tdata;    // vert_x [31:0], vert_y [63:32]
    logic [CORNER_W-1:0]    m_tuser;    // corner [1:0]
    logic                   m_tlast;

    logic calm;
    logic hold_req;
    logic hold;
    int   quiet_cycles = 0;
    int   settings_run = 0;

    quad_checker sb = new();

    sprite_quad_vertex_transform uut (
        .aclk,
        .aresetn,
        .cfg_valid,
        .cfg_ready,
        .cfg_index,
        .cfg_data,
        .s_tvalid,
        .s_tready,
        .s_tdata,
        .m_tvalid,
        .m_tready,
        .m_tdata,
        .m_tuser,
        .m_tlast
    );

    always #(CLK_PERIOD / 2.0) aclk = ~aclk;

    // Offer one sprite, wait for its acceptance, then, unless calm, maybe drop s_tvalid for a random gap
    task automatic send_sprite(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py);
        s_tvalid <= 1'b1;
        s_tdata  <= {py, px};
        do @(posedge aclk); while (!s_tready);
        sb.note_sprite(px, py);
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge aclk);
        end
    endtask

    // Drop the input and wait until every queued corner has come out
    task automatic stop_and_drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_one(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // Write all registers, slipping one write to an unmapped index in after odd_slot
    task automatic load_config(input cfg_set_t vals, input int odd_slot,
                               input logic [CFG_DATA_W-1:0] odd_data);
        int r;
        for (r = 0; r < NUM_REGS; r++) begin
            write_one(REG_CENTER_X + CFG_INDEX_W'(r), vals[r]);
            if (r == odd_slot) begin
                write_one(REG_SPARE_LO + CFG_INDEX_W'($urandom_range(0,
                          (1 << CFG_INDEX_W) - 1 - REG_SPARE_LO)), odd_data);
            end
        end
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: begin
                return $urandom;
            end
            5: begin
                return COORD_MAX - $urandom_range(0, 1 << 20);
            end
            6: begin
                return COORD_MIN + $urandom_range(0, 1 << 20);
            end
            default: begin
                return $urandom_range(0, 1 << 28) - (1 << 27);
            end
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_center();
        case ($urandom_range(0, 3))
            0: begin
                return $urandom;
            end
            1: begin
                return $urandom_range(0, 1 << 19) - (1 << 18);
            end
            2: begin
                return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
            end
            default: begin
                return '0;
            end
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_scale();
        logic [CFG_DATA_W-1:0] junk;
        logic [SCALE_W-1:0]    s;
        junk = $urandom;
        case ($urandom_range(0, 4))
            0: begin
                s = SCALE_ONE;
            end
            1: begin
                s = SCALE_W'($urandom);
            end
            2: begin
                s = SCALE_W'($urandom_range(0, 2048) - 1024);
            end
            3: begin
                s = $urandom_range(0, 1) ? {1'b0, {(SCALE_W-1){1'b1}}}
                                         : {1'b1, {(SCALE_W-1){1'b0}}};
            end
            default: begin
                s = '0;
            end
        endcase
        return {junk[CFG_DATA_W-1:SCALE_W], s};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_rect();
        logic [CFG_DATA_W-1:0] junk;
        logic [RECT_W-1:0]     r;
        junk = $urandom;
        case ($urandom_range(0, 4))
            0: begin
                r = RECT_W'($urandom);
            end
            1: begin
                r = RECT_W'($urandom_range(0, 64 << 16));
            end
            2: begin
                r = '1;
            end
            3: begin
                r = '0;
            end
            default: begin
                r = RECT_ONE;
            end
        endcase
        return {junk[CFG_DATA_W-1:RECT_W], r};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_angle();
        logic [CFG_DATA_W-1:0] junk;
        logic [ANGLE_W-1:0]    a;
        junk = $urandom;
        case ($urandom_range(0, 3))
            0: begin
                a = '0;
            end
            1: begin
                a = ANGLE_W'($urandom);
            end
            2: begin
                a = ANGLE_W'($urandom_range(0, 3) << (ANGLE_W - 2));
            end
            default: begin
                a = ANGLE_W'($urandom_range(1, 63));
            end
        endcase
        return {junk[CFG_DATA_W-1:ANGLE_W], a};
    endfunction

    function automatic cfg_set_t random_config();
        cfg_set_t vals;
        vals[REG_CENTER_X]    = pick_center();
        vals[REG_CENTER_Y]    = pick_center();
        vals[REG_SCALE_H]     = pick_scale();
        vals[REG_SCALE_V]     = pick_scale();
        vals[REG_RECT_WIDTH]  = pick_rect();
        vals[REG_RECT_HEIGHT] = pick_rect();
        vals[REG_TURN_ANGLE]  = pick_angle();
        vals[REG_TILT_ANGLE]  = pick_angle();
        return vals;
    endfunction

    // Result side: check each accepted vertex, then pick the next ready level
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                sb.check_vertex(m_tuser, m_tdata[COORD_W-1:0],
                                m_tdata[2*COORD_W-1:COORD_W], m_tlast);
            end
            if (hold) begin
                m_tready <= 1'b0;
            end else if (calm) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Hold the result side off once for a long stretch so the input backs up
    initial begin
        hold = 1'b0;
        wait (hold_req === 1'b1);
        @(posedge aclk);
        hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold <= 1'b0;
    end

    // End the run when nothing moves on any channel for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[%0t] timeout: %0d corners still queued", $realtime, sb.pending());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        int phase;
        int n;
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        calm      = 1'b0;
        hold_req  = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: zero, extreme and ordinary positions
        send_sprite('0, '0);
        send_sprite(COORD_MAX, COORD_MAX);
        send_sprite(COORD_MIN, COORD_MIN);
        send_sprite(32'h0012_8000, 32'hFFF0_4000);
        stop_and_drain();

        // Mirrored x, widest y scale, zero height, quarter turn
        load_config('{32'h0000_8000, 32'h0000_8000, 32'hA5A5_FF00, 32'h5A5A_7FFF,
                      32'hFFFF_FFFF, 32'h8000_0000, 32'h1234_4000, 32'h0000_2000},
                    3, $urandom);
        send_sprite('0, '0);
        send_sprite(32'h1234_0000, 32'hFFAA_0000);
        send_sprite(COORD_MAX, COORD_MIN);
        stop_and_drain();

        // Extreme centers and most negative scales, largest angles: saturation
        load_config('{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_8000, 32'hFFFF_8000,
                      32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF},
                    0, $urandom);
        send_sprite(COORD_MAX, COORD_MIN);
        send_sprite(COORD_MIN, COORD_MAX);
        send_sprite('0, '0);
        stop_and_drain();

        // No rotation, tilt to a quarter turn flattens y
        load_config('{32'h0000_0000, 32'h0002_0000, 32'h0000_0180, 32'h0000_0180,
                      32'h0003_0000, 32'h0002_8000, 32'hFFFF_0000, 32'h0000_4000},
                    7, $urandom);
        send_sprite(32'h0100_0000, 32'h0080_0000);
        send_sprite(32'hFFFF_0000, 32'h0000_0001);
        send_sprite(32'h7FFF_0000, 32'h8000_FFFF);
        stop_and_drain();

        // Angles too small to move off table entry zero, zero horizontal scale
        load_config('{32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000, 32'h0000_0100,
                      32'h0010_0000, 32'h0010_0000, 32'h0000_0001, 32'h0000_0001},
                    5, $urandom);
        send_sprite(32'h0040_0000, 32'h0040_0000);
        send_sprite(32'hFFC0_0001, 32'h0000_7FFF);
        send_sprite(COORD_MIN, COORD_MAX);
        stop_and_drain();

        // Three-quarter turn, half-turn tilt, zero width
        load_config('{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_7FFF, 32'h0000_FFFF,
                      32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_C000, 32'h0000_8000},
                    1, $urandom);
        send_sprite('0, '0);
        send_sprite(32'h0001_0000, 32'hFFFF_FFFF);
        send_sprite(COORD_MAX, COORD_MAX);
        stop_and_drain();

        // Random settings, each followed by a burst of random sprites
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            load_config(random_config(), $urandom_range(0, NUM_REGS - 1), $urandom);
            calm <= (phase == CALM_PHASE);
            if (phase == HOLD_PHASE) begin
                hold_req <= 1'b1;
            end
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_sprite(rand_coord(), rand_coord());
            end
            stop_and_drain();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Run: %0d sprites under %0d register settings (reset values, extremes,",
                 sb.sprites, settings_run + 1);
        $display("  mirrored and zero scales, zero and tiny angles, saturation); %0d corners ok",
                 sb.corners_ok);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d corners never arrived", sb.mismatches, sb.pending());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
